// ===== rtl/xrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xrg_pkg;

	localparam int VALUE_WIDTH = 32;

	localparam int SHIFT_A = 12;
	localparam int SHIFT_B = 25;
	localparam int SHIFT_C = 27;

	localparam logic [63:0] STAR_MULT = 64'd2685821657736338717;
	localparam logic [63:0] ZERO_SEED_SUBST = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] SEED_RESET = 64'd1;

	localparam logic signed [VALUE_WIDTH-1:0] PCT_TOP = VALUE_WIDTH'(99);
	localparam logic [VALUE_WIDTH:0] PCT_SPAN = (VALUE_WIDTH + 1)'(100);

	localparam logic [1:0] CMD_RANGE = 2'd0;
	localparam logic [1:0] CMD_PERCENT = 2'd1;
	localparam logic [1:0] CMD_EXCL = 2'd2;

	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

// ===== rtl/xorshift64star_range_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                         Direction
// req       req_valid/req_ready, command, value_a, value_b  in
// rsp       rsp_valid/rsp_ready, drawn_value, chance_hit,   out
//           state_word
// seed      seed_wr_en, seed_value                          in, write only
//
// A request that draws goes from transfer to result through a decode step,
// the shared 32x32 multiplier, the one-bit-per-cycle restoring divider and
// a step that forms the result, then back to idle before the next req
// transfer. A request without a draw goes from decode straight to forming
// its result. Reset loads the state with 1. A stalled rsp holds the finished
// request in its last step and keeps req_ready low.

module xorshift64star_range_generator
	import xrg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_wr_en,
	input  wire logic [63:0] seed_value,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] value_a,
	input  wire logic [31:0] value_b,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [31:0]      drawn_value,
	output logic             chance_hit,
	output logic [63:0]      state_word
);

	localparam int VW = VALUE_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] st_q;
	logic [63:0] gen_q;
	logic [1:0] cmd_q;
	logic signed [VW-1:0] a_q, b_q, lo_q, val_q, res_val_q;
	logic hit_q, res_hit_q, drew_q, rsp_valid_q;
	logic [VW:0] div_q, rem_q;
	logic [1:0] mul_cnt_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [63:0] acc_q, prod_q, res_state_q;

	logic [63:0] xs1, xs2, xs3;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_w;
	logic signed [VW-1:0] lo_w, hi_w;
	logic [VW:0] span_w, trial_w;
	logic out_free;
	logic draw_w;

	assign xs1 = gen_q ^ (gen_q >> SHIFT_A);
	assign xs2 = xs1 ^ (xs1 << SHIFT_B);
	assign xs3 = xs2 ^ (xs2 >> SHIFT_C);

	assign mul_a = (mul_cnt_q == 2'd1) ? gen_q[63:32] : gen_q[31:0];
	assign mul_b = (mul_cnt_q == 2'd2) ? STAR_MULT[63:32] : STAR_MULT[31:0];
	assign prod_w = 64'(mul_a) * 64'(mul_b);

	assign lo_w = (a_q < b_q) ? a_q : b_q;
	assign hi_w = (a_q < b_q) ? b_q : a_q;
	assign span_w = {hi_w[VW-1], hi_w} - {lo_w[VW-1], lo_w} + (VW + 1)'(1);

	assign draw_w = (cmd_q == CMD_RANGE) ? (a_q != b_q) :
			(cmd_q == CMD_PERCENT) ? ((a_q > VW'(0)) && !(a_q > PCT_TOP)) :
			(cmd_q == CMD_EXCL) ? (a_q > VW'(1)) : 1'b0;

	assign trial_w = {rem_q[VW-1:0], acc_q[63]};

	assign out_free = !rsp_valid_q || rsp_ready;

	assign req_ready = (st_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign drawn_value = 32'(res_val_q);
	assign chance_hit = res_hit_q;
	assign state_word = res_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			gen_q <= SEED_RESET;
			rsp_valid_q <= 1'b0;
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (seed_wr_en) begin
				gen_q <= (seed_value == 64'd0) ? ZERO_SEED_SUBST : seed_value;
			end
			case (st_q)
				ST_IDLE: begin
					if (req_valid) begin
						st_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (draw_w) begin
						gen_q <= xs3;
						mul_cnt_q <= '0;
						st_q <= ST_MUL;
					end else begin
						st_q <= ST_FIN;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 2'd1;
					if (mul_cnt_q == 2'd3) begin
						div_cnt_q <= '0;
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd_q <= command;
					a_q <= value_a[VW-1:0];
					b_q <= value_b[VW-1:0];
					drew_q <= 1'b0;
				end
			end
			ST_DEC: begin
				val_q <= '0;
				hit_q <= 1'b0;
				lo_q <= lo_w;
				rem_q <= '0;
				drew_q <= 1'b0;
				case (cmd_q)
					CMD_RANGE: begin
						if (a_q == b_q) begin
							val_q <= a_q;
						end else begin
							div_q <= span_w;
							drew_q <= 1'b1;
						end
					end
					CMD_PERCENT: begin
						if (a_q > PCT_TOP) begin
							hit_q <= 1'b1;
						end else if (a_q > VW'(0)) begin
							div_q <= PCT_SPAN;
							drew_q <= 1'b1;
						end
					end
					CMD_EXCL: begin
						if (a_q > VW'(1)) begin
							div_q <= {1'b0, a_q};
							drew_q <= 1'b1;
						end
					end
					default: begin
						drew_q <= 1'b0;
					end
				endcase
			end
			ST_MUL: begin
				prod_q <= prod_w;
				case (mul_cnt_q)
					2'd1: acc_q <= prod_q;
					2'd2, 2'd3: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
					default: acc_q <= acc_q;
				endcase
			end
			ST_DIV: begin
				acc_q <= {acc_q[62:0], 1'b0};
				if (trial_w >= div_q) begin
					rem_q <= trial_w - div_q;
				end else begin
					rem_q <= trial_w;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					res_state_q <= gen_q;
					res_val_q <= val_q;
					res_hit_q <= hit_q;
					if (drew_q) begin
						case (cmd_q)
							CMD_RANGE: res_val_q <= rem_q[VW-1:0] + lo_q;
							CMD_PERCENT: res_hit_q <= (rem_q < {1'b0, a_q});
							CMD_EXCL: res_val_q <= rem_q[VW-1:0];
							default: res_val_q <= val_q;
						endcase
					end
				end
			end
			default: begin
				drew_q <= 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire
